>>> rtl/core/sws_pkg.sv
`default_nettype none

package sws_pkg;

  // Index and sequence widths
  localparam int IDX_W      = 17;
  localparam int SEQ_W      = 16;
  localparam int ACK_W      = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // At most this many send orders come out of one event
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_SEQ    = 2'd2;

  localparam logic [4:0] WINDOW_RESET = 5'd8;

  // Input operations
  localparam logic [1:0] OP_FILL    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Only this acknowledgement type marks packets
  localparam logic [1:0] ACK_TYPE_VALID = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [1:0]       ack_type;
    logic [ACK_W-1:0] ack_sequence;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [SEQ_W-1:0] packet_sequence;
    logic             is_retransmit;
    logic [IDX_W-1:0] window_base;
    logic             transfer_done;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  window_size;
    logic [15:0] data_packet_count;
    logic [13:0] start_sequence;
  } cfg_t;

  // One result from the sequencer toward the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

endpackage

`default_nettype wire

>>> rtl/core/sws_cfg.sv
`default_nettype none

module sws_cfg #(
  parameter int WINDOW_MAX = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [sws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sws_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sws_pkg::cfg_t                         cfg,
  output logic [$clog2(WINDOW_MAX+1)-1:0]       eff_window
);
  import sws_pkg::*;

  localparam int WIN_W = $clog2(WINDOW_MAX + 1);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_size       <= WINDOW_RESET;
      cfg.data_packet_count <= '0;
      cfg.start_sequence    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:  cfg.window_size       <= cfg_data[4:0];
        REG_PACKET_COUNT: cfg.data_packet_count <= cfg_data[15:0];
        REG_START_SEQ:    cfg.start_sequence    <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // Window clamped to 1..WINDOW_MAX
  always_comb begin
    if (cfg.window_size == 5'd0) begin
      eff_window = WIN_W'(1);
    end else if (32'(cfg.window_size) > WINDOW_MAX) begin
      eff_window = WIN_W'(WINDOW_MAX);
    end else begin
      eff_window = WIN_W'(cfg.window_size);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sws_seq.sv
`default_nettype none

module sws_seq #(
  parameter int WINDOW_MAX = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire sws_pkg::cfg_t                     cfg,
  input  wire logic [$clog2(WINDOW_MAX+1)-1:0]   eff_window,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire sws_pkg::in_item_t                 in_data,
  output sws_pkg::emit_t                         emit,
  input  wire logic                              emit_ready
);
  import sws_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_WALK       = 6'b000010,
    S_FLUSH      = 6'b000100,
    S_SLIDE_DATA = 6'b001000,
    S_SLIDE_END  = 6'b010000,
    S_STATUS     = 6'b100000
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] base_index;
  logic [IDX_W-1:0] next_index;
  logic [ACK_W-1:0] highest_ack;
  logic             end_acked;

  // Walk unit registers
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] stop;
  logic             retx;
  logic [CNT_W-1:0] cnt;
  out_item_t        held;
  logic             held_valid;

  logic [IDX_W-1:0] size;
  logic [IDX_W-1:0] end_idx;
  logic             done_flag;
  logic             accept;

  logic [IDX_W-1:0] fill_start;
  logic [IDX_W:0]   lim_raw;
  logic [IDX_W-1:0] fill_limit;
  logic [IDX_W-1:0] fill_next;
  logic [IDX_W-1:0] tmo_stop;

  logic             cur_acked;
  logic             walk_live;
  logic             cand;
  logic             stall;
  logic [IDX_W-1:0] cur_m1;
  out_item_t        cand_item;
  out_item_t        status_item;
  logic [ACK_W:0]   ha_p1;
  logic [IDX_W-1:0] slide_base;

  assign size      = {1'b0, cfg.data_packet_count} + IDX_W'(2);
  assign end_idx   = {1'b0, cfg.data_packet_count} + IDX_W'(1);
  assign done_flag = (base_index >= size);
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;

  // Fill range: from max(next, base) up to min(base + window, size)
  always_comb begin
    fill_start = (next_index < base_index) ? base_index : next_index;
    lim_raw    = {1'b0, base_index} + (IDX_W+1)'(eff_window);
    fill_limit = (lim_raw > {1'b0, size}) ? size : lim_raw[IDX_W-1:0];
    fill_next  = (fill_start >= fill_limit) ? fill_start : fill_limit;
    tmo_stop   = (next_index < size) ? next_index : size;
  end

  // Acknowledged test for the index under the walk unit
  always_comb begin
    if (cur == '0) begin
      cur_acked = 1'b1;
    end else if (cur < end_idx) begin
      cur_acked = ({15'd0, cur} <= highest_ack);
    end else if (cur == end_idx) begin
      cur_acked = end_acked;
    end else begin
      cur_acked = 1'b1;
    end
  end

  assign walk_live = (cur < stop) && (cnt < CNT_W'(MAX_OUT));
  assign cand      = walk_live && !cur_acked;
  assign stall     = cand && held_valid && !emit_ready;
  assign cur_m1    = cur - IDX_W'(1);

  // Send order for the current index
  always_comb begin
    cand_item.result_kind     = (cur == end_idx) ? KIND_END : KIND_DATA;
    cand_item.packet_sequence = (cur == end_idx) ? {2'b00, cfg.start_sequence}
                                                 : cur_m1[SEQ_W-1:0];
    cand_item.is_retransmit   = retx;
    cand_item.window_base     = base_index;
    cand_item.transfer_done   = done_flag;
    cand_item.last_of_run     = 1'b0;
  end

  always_comb begin
    status_item.result_kind     = KIND_STATUS;
    status_item.packet_sequence = '0;
    status_item.is_retransmit   = 1'b0;
    status_item.window_base     = base_index;
    status_item.transfer_done   = done_flag;
    status_item.last_of_run     = 1'b1;
  end

  // Result toward the output register; the held order goes out once the
  // next one is found, or with last set when the walk ends
  always_comb begin
    emit.valid = 1'b0;
    emit.item  = held;
    unique case (state)
      S_WALK: begin
        emit.valid = cand && held_valid;
      end
      S_FLUSH: begin
        emit.valid            = held_valid;
        emit.item.last_of_run = 1'b1;
      end
      S_STATUS: begin
        emit.valid = 1'b1;
        emit.item  = status_item;
      end
      default: ;
    endcase
  end

  // Base slide over the cumulatively acknowledged data packets
  always_comb begin
    ha_p1      = {1'b0, highest_ack} + (ACK_W+1)'(1);
    slide_base = base_index;
    if ((base_index < end_idx) && ({15'd0, base_index} <= highest_ack)) begin
      slide_base = (ha_p1 < (ACK_W+1)'(end_idx)) ? ha_p1[IDX_W-1:0] : end_idx;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      base_index  <= IDX_W'(1);
      next_index  <= IDX_W'(1);
      highest_ack <= '0;
      end_acked   <= 1'b0;
      held_valid  <= 1'b0;
      cnt         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            held_valid <= 1'b0;
            cnt        <= '0;
            if (in_data.operation == OP_FILL) begin
              cur        <= fill_start;
              stop       <= fill_limit;
              retx       <= 1'b0;
              next_index <= fill_next;
              state      <= S_WALK;
            end else if (in_data.operation == OP_TIMEOUT) begin
              cur   <= base_index;
              stop  <= tmo_stop;
              retx  <= 1'b1;
              state <= S_WALK;
            end else if (in_data.operation == OP_ACK) begin
              if (in_data.ack_type == ACK_TYPE_VALID) begin
                if (in_data.ack_sequence > highest_ack) begin
                  highest_ack <= in_data.ack_sequence;
                end
                if (in_data.ack_sequence == {18'd0, cfg.start_sequence}) begin
                  end_acked <= 1'b1;
                end
              end
              state <= S_SLIDE_DATA;
            end
          end
        end
        S_WALK: begin
          if (!walk_live) begin
            state <= held_valid ? S_FLUSH : S_IDLE;
          end else if (!stall) begin
            cur <= cur + IDX_W'(1);
            if (cand) begin
              held       <= cand_item;
              held_valid <= 1'b1;
              cnt        <= cnt + CNT_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (emit_ready) begin
            held_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_SLIDE_DATA: begin
          base_index <= slide_base;
          state      <= S_SLIDE_END;
        end
        S_SLIDE_END: begin
          if ((base_index == end_idx) && end_acked) begin
            base_index <= base_index + IDX_W'(1);
          end
          state <= S_STATUS;
        end
        S_STATUS: begin
          if (emit_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sliding_window_sender.sv
// Sliding-window sender, go-back-N style.
// Configuration: cfg_write with cfg_index 0 (window size), 1 (data packet
// count) or 2 (start sequence) and cfg_data; write only while idle.
// Input channel (in_valid/in_ready/in_data): one event per transfer, either
// fill window, acknowledgement or timeout. in_ready is high only while the
// sequencer is idle; one event is worked at a time.
// Output channel (out_valid/out_ready/out_data): send orders and status
// items, the final item of each event marked by last_of_run.
// Fill and timeout: the walk unit visits one packet index per cycle while
// the output is not stalled, then flushes the last send order when there
// is one; each held send order passes to the output register once the
// next one is found, the last one after the walk ends.
// Acknowledgement: accept, data slide, end-packet slide, status, in that
// order; the status item is registered on the output.
// Sends come out at up to one per cycle. A stalled receiver holds the
// output register and the walk waits; nothing is dropped.
// Reset (rst, synchronous): base and next index 1, no acks, window 8.
`default_nettype none

module sliding_window_sender #(
  parameter int WINDOW_MAX = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [sws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sws_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire sws_pkg::in_item_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output sws_pkg::out_item_t                    out_data
);
  import sws_pkg::*;

  localparam int WIN_W = $clog2(WINDOW_MAX + 1);

  cfg_t             cfg;
  logic [WIN_W-1:0] eff_window;
  emit_t            emit;
  logic             emit_ready;

  sws_cfg #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .eff_window (eff_window)
  );

  sws_seq #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .eff_window (eff_window),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .emit       (emit),
    .emit_ready (emit_ready)
  );

  // Output register; refills in the cycle its transfer completes
  assign emit_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_ready) begin
      out_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit.valid) begin
      out_data <= emit.item;
    end
  end

endmodule

`default_nettype wire
